@@ design/u8d_pkg.sv @@
// Package for the UTF-8 stream decoder: beat payload types, lead-byte
// classification and the merge functions for 2-, 3- and 4-byte sequences.
// Depends on nothing.
package u8d_pkg;

  // Input beat: one raw byte of the string and its last-byte flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } u8d_in_t;

  // Output beat: one code point and its end-of-string mark.
  typedef struct packed {
    logic [20:0] code_point;
    logic        string_end;
  } u8d_out_t;

  localparam int unsigned MaxResults = 3;

  // Results that one input beat produces, listed in delivery order.
  typedef struct packed {
    logic [1:0]                    count;
    u8d_out_t [MaxResults-1:0]     item;
  } u8d_res_t;

  localparam logic [2:0] LenSingle = 3'd1;
  localparam logic [2:0] LenTwo    = 3'd2;
  localparam logic [2:0] LenThree  = 3'd3;
  localparam logic [2:0] LenFour   = 3'd4;

  // Sequence length announced by a lead byte, or one for a byte that stands alone.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if ((b & 8'hE0) == 8'hC0) begin
      len = LenTwo;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = LenThree;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = LenFour;
    end else begin
      len = LenSingle;
    end
    return len;
  endfunction

  // A byte given as its own value.
  function automatic logic [20:0] raw_cp(input logic [7:0] b);
    return {13'd0, b};
  endfunction

  function automatic logic [20:0] merge2(input logic [7:0] b0, input logic [7:0] b1);
    return {10'd0, b0[4:0], b1[5:0]};
  endfunction

  function automatic logic [20:0] merge3(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2);
    return {5'd0, b0[3:0], b1[5:0], b2[5:0]};
  endfunction

  function automatic logic [20:0] merge4(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3);
    return {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
  endfunction

endpackage

@@ design/utf8_stream_decoder.sv @@
// UTF-8 stream decoder: one string byte per input beat, code points out.
// A result is offered in the cycle after its last byte. Throughput: one byte
// per cycle while out_ready_i is high; a string that ends inside a sequence
// gives two or three results; the input waits until all but the last leaves.
// Reset (rst_ni, asynchronous, active low) closes any open sequence and
// empties the result buffer; no clearing pass is needed.
module utf8_stream_decoder
  import u8d_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  u8d_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output u8d_out_t out_data_o
);

  u8d_res_t dec_res;
  logic     accept;

  assign accept = in_valid_i && in_ready_o;

  u8d_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_data_i),
    .res_o    (dec_res)
  );

  u8d_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && (dec_res.count != 2'd0)),
    .res_i       (dec_res),
    .can_load_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A beat that yields results must show a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && dec_res.count != 2'd0) |=> out_valid_o)
    else $error("decoded result was not presented");

  // Several results from one byte only happen at the end of a string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && dec_res.count > 2'd1) |-> in_data_i.final_byte)
    else $error("multiple results from a byte that is not final");

  // The input is open only when any pending result leaves in this cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_o || out_ready_i))
    else $error("input accepted while results are still waiting");

endmodule

@@ design/u8d_decode.sv @@
// Decode stage of the UTF-8 stream decoder: holds the bytes of an open
// sequence and turns each input beat into zero to three results.
// Depends on u8d_pkg.
module u8d_decode
  import u8d_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  u8d_in_t  in_i,
  output u8d_res_t res_o
);

  logic [7:0] held_q [MaxResults];
  logic [1:0] held_cnt_q, held_cnt_d;
  logic [2:0] seq_len_q, seq_len_d;
  logic       hold_wr;
  logic [1:0] hold_idx;

  logic [7:0] b;
  logic       fin;
  logic [2:0] b_len;
  logic [2:0] n_bytes;

  assign b       = in_i.data_byte;
  assign fin     = in_i.final_byte;
  assign b_len   = lead_len(b);
  assign n_bytes = {1'b0, held_cnt_q} + 3'd1;

  // Result and next-state selection for one beat.
  always_comb begin
    res_o      = '0;
    held_cnt_d = held_cnt_q;
    seq_len_d  = seq_len_q;
    hold_wr    = 1'b0;
    hold_idx   = held_cnt_q;

    if (held_cnt_q == 2'd0) begin
      if (b_len != LenSingle && !fin) begin
        // Lead byte opens a sequence.
        hold_wr    = 1'b1;
        hold_idx   = 2'd0;
        held_cnt_d = 2'd1;
        seq_len_d  = b_len;
      end else begin
        res_o.count                 = 2'd1;
        res_o.item[0].code_point    = raw_cp(b);
        res_o.item[0].string_end    = fin;
      end
    end else if (n_bytes >= seq_len_q) begin
      // This byte completes the open sequence.
      res_o.count              = 2'd1;
      res_o.item[0].string_end = fin;
      unique case (seq_len_q)
        LenTwo:   res_o.item[0].code_point = merge2(held_q[0], b);
        LenThree: res_o.item[0].code_point = merge3(held_q[0], held_q[1], b);
        LenFour:  res_o.item[0].code_point = merge4(held_q[0], held_q[1], held_q[2], b);
        default:  res_o.item[0].code_point = raw_cp(b);
      endcase
      held_cnt_d = 2'd0;
      seq_len_d  = 3'd0;
    end else if (!fin) begin
      // Sequence still in flight: keep the byte.
      hold_wr    = 1'b1;
      held_cnt_d = held_cnt_q + 2'd1;
    end else begin
      // String ended inside a sequence. The lead cannot fit and goes out raw;
      // with two held bytes the second may still start a 2-byte sequence.
      res_o.item[0].code_point = raw_cp(held_q[0]);
      res_o.item[0].string_end = 1'b0;
      if (held_cnt_q == 2'd1) begin
        res_o.count              = 2'd2;
        res_o.item[1].code_point = raw_cp(b);
        res_o.item[1].string_end = 1'b1;
      end else if (lead_len(held_q[1]) == LenTwo) begin
        res_o.count              = 2'd2;
        res_o.item[1].code_point = merge2(held_q[1], b);
        res_o.item[1].string_end = 1'b1;
      end else begin
        res_o.count              = 2'd3;
        res_o.item[1].code_point = raw_cp(held_q[1]);
        res_o.item[1].string_end = 1'b0;
        res_o.item[2].code_point = raw_cp(b);
        res_o.item[2].string_end = 1'b1;
      end
      held_cnt_d = 2'd0;
      seq_len_d  = 3'd0;
    end
  end

  // Sequence bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
      seq_len_q  <= 3'd0;
    end else if (accept_i) begin
      held_cnt_q <= held_cnt_d;
      seq_len_q  <= seq_len_d;
    end
  end

  // Held bytes carry no reset; an entry is read only after it is written.
  always_ff @(posedge clk_i) begin
    if (accept_i && hold_wr) begin
      held_q[hold_idx] <= b;
    end
  end

endmodule

@@ design/u8d_outbuf.sv @@
// Result buffer of the UTF-8 stream decoder: holds up to three results of one
// input beat and hands them out one beat at a time.
// Depends on u8d_pkg.
module u8d_outbuf
  import u8d_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  u8d_res_t res_i,
  output logic     can_load_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output u8d_out_t out_data_o
);

  u8d_out_t   ent_q [MaxResults];
  logic [1:0] cnt_q;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = ent_q[0];
  assign pop         = out_valid_o && out_ready_i;
  // New results may enter once the buffer is empty or drains its last beat now.
  assign can_load_o  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i);

  // Occupancy count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= res_i.count;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // Entries load in delivery order and shift toward the head on each pop.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q[0] <= res_i.item[0];
      ent_q[1] <= res_i.item[1];
      ent_q[2] <= res_i.item[2];
    end else if (pop) begin
      ent_q[0] <= ent_q[1];
      ent_q[1] <= ent_q[2];
    end
  end

endmodule
